// ----- hw/rtl/arpc_pkg.sv -----
package arpc_pkg;

  localparam int TABLE_SIZE_DEF = 8;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_PACKET = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_PENDING  = 2'd1;
  localparam logic [1:0] ST_RESOLVED = 2'd2;

  localparam logic [1:0] REG_OWN_IP   = 2'd0;
  localparam logic [1:0] REG_ENTRY_LT = 2'd1;
  localparam logic [1:0] REG_REQ_LT   = 2'd2;

  localparam logic [15:0] ENTRY_LT_RST = 16'd600;
  localparam logic [15:0] REQ_LT_RST   = 16'd10;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [31:0] target_ip;
    logic [15:0] opcode;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] pkt_len;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [47:0] found_mac;
    logic        send_request;
    logic        send_reply;
    logic [31:0] frame_ip;
    logic [47:0] frame_mac;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_TICK,
    OP_NONE
  } op_t;

  // classified item passed from front to back
  typedef struct packed {
    op_t         op;
    logic        reply;
    logic [31:0] ip;
    logic [47:0] mac;
  } job_t;

endpackage

// ----- hw/rtl/arpc_front.sv -----
module arpc_front (
  input  logic              start,
  output logic              busy,
  input  arpc_pkg::in_item_t item,
  input  logic [31:0]       own_ip,
  input  logic              q_full,
  output logic              q_push,
  output arpc_pkg::job_t    q_data
);
  import arpc_pkg::*;

  logic ok;

  assign ok = (item.pkt_len >= 16'd28) && (item.hw_len == 8'd6) &&
              (item.proto_len == 8'd4) && (item.hw_type == 16'd1) &&
              (item.proto_type == 16'h0800) && (item.target_ip == own_ip) &&
              ((item.opcode == 16'd1) || (item.opcode == 16'd2));

  assign busy   = q_full;
  assign q_push = start && !busy;

  always_comb begin
    q_data.ip    = item.ip_addr;
    q_data.mac   = item.mac_addr;
    q_data.reply = 1'b0;
    case (item.command)
      CMD_LOOKUP: q_data.op = OP_LOOKUP;
      CMD_PACKET: begin
        q_data.op    = ok ? OP_INSERT : OP_NONE;
        q_data.reply = ok && (item.opcode == 16'd1);
      end
      CMD_TICK: q_data.op = OP_TICK;
      default: q_data.op = OP_NONE;
    endcase
  end
endmodule

// ----- hw/rtl/arpc_queue.sv -----
module arpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  arpc_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output arpc_pkg::job_t pop_data
);
  import arpc_pkg::*;

  job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full     = (cnt == 2'd2);
  assign avail    = (cnt != 2'd0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- hw/rtl/arpc_back.sv -----
module arpc_back #(
  parameter int TABLE_SIZE = arpc_pkg::TABLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  arpc_pkg::job_t     job,
  output logic               pop,
  input  logic [15:0]        entry_lifetime,
  input  logic [15:0]        request_lifetime,
  output logic               done,
  output arpc_pkg::out_item_t result
);
  import arpc_pkg::*;

  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [IW:0] LAST = (IW + 1)'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  job_t   cur;
  logic [IW:0] idx;

  logic [1:0]  st  [TABLE_SIZE];
  logic [31:0] eip [TABLE_SIZE];
  logic [47:0] emac[TABLE_SIZE];
  logic [15:0] eage[TABLE_SIZE];

  logic          have_empty, have_pick;
  logic [IW-1:0] last_empty, pick;
  logic [15:0]   min_age;

  logic [IW-1:0] i;
  logic          used, hit, last, stop;
  assign i    = idx[IW-1:0];
  assign used = st[i] != ST_EMPTY;
  assign hit  = used && (eip[i] == cur.ip);
  assign last = idx == LAST;
  // matching pending or resolved entry ends a lookup or insert scan
  assign stop = hit && ((st[i] == ST_PENDING) || (st[i] == ST_RESOLVED));
  assign pop  = (state == S_IDLE) && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      result <= '0;
      for (int k = 0; k < TABLE_SIZE; k++) begin
        st[k] <= ST_EMPTY;
        eip[k] <= '0;
        emac[k] <= '0;
        eage[k] <= '0;
      end
    end else begin
      done <= (state == S_DONE) || ((state == S_SCAN) && (cur.op == OP_LOOKUP) && stop);
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            cur <= job;
            idx <= '0;
            have_empty <= 1'b0;
            have_pick <= 1'b0;
            last_empty <= '0;
            pick <= '0;
            min_age <= entry_lifetime;
            result <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (stop && cur.op == OP_LOOKUP) state <= S_IDLE;
          else if ((stop && cur.op == OP_INSERT) || last) state <= S_DONE;
          else state <= S_SCAN;
          case (cur.op)
            OP_LOOKUP: begin
              if (!used) begin
                have_empty <= 1'b1;
                last_empty <= i;
              end else if (hit && st[i] == ST_RESOLVED) begin
                eage[i] <= entry_lifetime;
                result.found <= 1'b1;
                result.found_mac <= emac[i];
              end
            end
            OP_INSERT: begin
              if (hit && st[i] == ST_PENDING) begin
                have_pick <= 1'b1;
                pick <= i;
              end else if (hit && st[i] == ST_RESOLVED) begin
                eage[i] <= entry_lifetime;
                have_pick <= 1'b0;
              end else if (eage[i] < min_age) begin
                min_age <= eage[i];
                have_pick <= 1'b1;
                pick <= i;
              end
            end
            OP_TICK: begin
              if (used) begin
                if (eage[i] != 16'd0) eage[i] <= eage[i] - 16'd1;
                else st[i] <= ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
        S_DONE: begin
          state <= S_IDLE;
          case (cur.op)
            OP_LOOKUP: begin
              if (have_empty) begin
                eip[last_empty] <= cur.ip;
                st[last_empty] <= ST_PENDING;
                eage[last_empty] <= request_lifetime;
              end
              result.send_request <= 1'b1;
              result.frame_ip <= cur.ip;
            end
            OP_INSERT: begin
              if (have_pick) begin
                eage[pick] <= entry_lifetime;
                st[pick] <= ST_RESOLVED;
                eip[pick] <= cur.ip;
                emac[pick] <= cur.mac;
              end
              result.found <= 1'b1;
              if (cur.reply) begin
                result.send_reply <= 1'b1;
                result.frame_ip <= cur.ip;
                result.frame_mac <= cur.mac;
              end
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/arp_cache_engine.sv -----
// channel  direction  handshake          payload
// cmd      in         start / busy       item (in_item_t)
// result   out        done strobe        result (out_item_t)
// cfg      in         cfg_valid/ready    cfg_index, cfg_data
// the back end handles an item in steps: pick-up, one entry per scan cycle,
// finish; a lookup or packet that matches an entry ends the scan early
// done is registered from the finish step, or from the scan of a matching lookup
// a two-entry queue lets start be taken during a scan; busy only while it is full
// synchronous reset empties all entries at once; results cannot be stalled
module arp_cache_engine #(
  parameter int TABLE_SIZE = arpc_pkg::TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  arpc_pkg::in_item_t  item,
  output logic                done,
  output arpc_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import arpc_pkg::*;

  logic [31:0] own_ip;
  logic [15:0] entry_lifetime, request_lifetime;
  logic q_full, q_push, q_pop, q_avail;
  job_t q_in, q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
      entry_lifetime <= ENTRY_LT_RST;
      request_lifetime <= REQ_LT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OWN_IP:   own_ip <= cfg_data;
        REG_ENTRY_LT: entry_lifetime <= cfg_data[15:0];
        REG_REQ_LT:   request_lifetime <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  arpc_front u_front (
    .start, .busy, .item, .own_ip,
    .q_full, .q_push, .q_data(q_in)
  );

  arpc_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .avail(q_avail), .pop_data(q_out)
  );

  arpc_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk, .rst, .avail(q_avail), .job(q_out), .pop(q_pop),
    .entry_lifetime, .request_lifetime, .done, .result
  );
endmodule
